// File: hw/rtl/pjb_pkg.sv
`timescale 1ns / 1ps

package pjb_pkg;

	// Field widths fixed by the interface
	localparam int DESC_W  = 32;
	localparam int STAMP_W = 64;
	localparam int FILL_W  = 5;
	localparam int THR_W   = 5;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);

	// Request codes
	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_TAKE  = 2'd1,
		REQ_TIMED = 2'd2,
		REQ_RESET = 2'd3
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_BUFFERING = 2'd2,
		ST_LATE      = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    accept;     // latch the request fields
		logic    put;        // store at tail
		logic    clear;      // empty the queue
		logic    rd_head;    // read entry at head
		logic    rd_next;    // read entry after head
		logic    load_hold;  // keep the last read entry
		logic    advance;    // drop the head entry
		logic    pop;        // take the head entry
		logic    use_hold;   // taken entry comes from the hold register
		logic    finish;     // load the result registers
		status_t status;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic buffering;
		logic count_gt1;
		logic rd_later;      // read stamp later than target
		logic rd_equal;      // read stamp equal to target
	} flags_t;

endpackage

// File: hw/rtl/pjb_datapath.sv
`timescale 1ns / 1ps

module pjb_datapath
	import pjb_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output flags_t                    flags,
	input  logic [1:0]                req_type,
	input  logic [DESC_W-1:0]         frame_descriptor,
	input  logic signed [STAMP_W-1:0] frame_stamp,
	input  logic signed [STAMP_W-1:0] target_stamp,
	input  logic [THR_W-1:0]          threshold,
	output logic [1:0]                status,
	output logic [DESC_W-1:0]         out_descriptor,
	output logic signed [STAMP_W-1:0] out_stamp,
	output logic                      is_buffering,
	output logic [FILL_W-1:0]         fill_level
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > THR_W) ? CW : THR_W;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	logic [DESC_W-1:0]         desc_mem [DEPTH];
	logic [STAMP_W-1:0]        stamp_mem [DEPTH];

	req_t                      req_q;
	logic [DESC_W-1:0]         desc_in_q;
	logic signed [STAMP_W-1:0] stamp_in_q;
	logic signed [STAMP_W-1:0] target_q;

	logic [IW-1:0]             head_q, tail_q;
	logic [CW-1:0]             count_q, count_d;
	logic                      buf_q, buf_d;

	logic [DESC_W-1:0]         rd_desc_q, hold_desc_q;
	logic signed [STAMP_W-1:0] rd_stamp_q, hold_stamp_q;
	logic [IW-1:0]             rd_addr;

	logic [CW-1:0]             count_inc;
	logic [CW-1:0]             count_dec;

	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign rd_addr   = cmd.rd_next ? next_idx(head_q) : head_q;

	// Next fill and buffering flag
	always_comb begin
		count_d = count_q;
		buf_d   = buf_q;
		if (cmd.put) begin
			count_d = count_inc;
			if (buf_q && (MW'(count_inc) >= MW'(threshold))) begin
				buf_d = 1'b0;
			end
		end else if (cmd.advance) begin
			count_d = count_dec;
		end else if (cmd.pop) begin
			count_d = count_dec;
			if (count_dec == '0) begin
				buf_d = 1'b1;
			end
		end else if (cmd.clear) begin
			count_d = '0;
			buf_d   = 1'b1;
		end
	end

	// Queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			buf_q   <= 1'b1;
		end else begin
			count_q <= count_d;
			buf_q   <= buf_d;
			if (cmd.put) begin
				tail_q <= next_idx(tail_q);
			end
			if (cmd.advance || cmd.pop) begin
				head_q <= next_idx(head_q);
			end
			if (cmd.clear) begin
				tail_q <= head_q;
			end
		end
	end

	// Latch the request item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q      <= req_t'(req_type);
			desc_in_q  <= frame_descriptor;
			stamp_in_q <= frame_stamp;
			target_q   <= target_stamp;
		end
	end

	// Entry store: write at tail, registered read
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			desc_mem[tail_q]  <= desc_in_q;
			stamp_mem[tail_q] <= stamp_in_q;
		end
		if (cmd.rd_head || cmd.rd_next) begin
			rd_desc_q  <= desc_mem[rd_addr];
			rd_stamp_q <= stamp_mem[rd_addr];
		end
	end

	// Hold the candidate entry during a timed take
	always_ff @(posedge clk) begin
		if (cmd.load_hold) begin
			hold_desc_q  <= rd_desc_q;
			hold_stamp_q <= rd_stamp_q;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status       <= cmd.status;
			is_buffering <= buf_d;
			fill_level   <= FILL_W'(count_d);
			if (cmd.pop) begin
				out_descriptor <= cmd.use_hold ? hold_desc_q : rd_desc_q;
				out_stamp      <= cmd.use_hold ? hold_stamp_q : rd_stamp_q;
			end else begin
				out_descriptor <= '0;
				out_stamp      <= '0;
			end
		end
	end

	assign flags.req       = req_q;
	assign flags.full      = (count_q == CW'(DEPTH));
	assign flags.empty     = (count_q == '0);
	assign flags.buffering = buf_q;
	assign flags.count_gt1 = (count_q > CW'(1));
	assign flags.rd_later  = (rd_stamp_q > target_q);
	assign flags.rd_equal  = (rd_stamp_q == target_q);

endmodule

// File: hw/rtl/pjb_ctrl.sv
`timescale 1ns / 1ps

module pjb_ctrl
	import pjb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	output logic   done,
	input  flags_t flags,
	output cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TAKE_CHK,
		S_HEAD_CHK,
		S_NEXT_RD,
		S_NEXT_CHK
	} state_t;

	state_t state_q, state_d;

	// Command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				case (flags.req)
					REQ_PUT: begin
						cmd.finish = 1'b1;
						if (flags.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.put    = 1'b1;
							cmd.status = ST_DONE;
						end
						state_d = S_IDLE;
					end
					REQ_TAKE, REQ_TIMED: begin
						if (flags.buffering || flags.empty) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BUFFERING;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = (flags.req == REQ_TAKE) ? S_TAKE_CHK : S_HEAD_CHK;
						end
					end
					default: begin
						cmd.clear  = 1'b1;
						cmd.finish = 1'b1;
						cmd.status = ST_DONE;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_TAKE_CHK: begin
				cmd.pop    = 1'b1;
				cmd.finish = 1'b1;
				cmd.status = ST_DONE;
				state_d    = S_IDLE;
			end
			S_HEAD_CHK: begin
				if (flags.rd_later) begin
					cmd.finish = 1'b1;
					cmd.status = ST_LATE;
					state_d    = S_IDLE;
				end else if (flags.rd_equal) begin
					cmd.pop    = 1'b1;
					cmd.finish = 1'b1;
					cmd.status = ST_DONE;
					state_d    = S_IDLE;
				end else begin
					cmd.load_hold = 1'b1;
					state_d       = S_NEXT_RD;
				end
			end
			S_NEXT_RD: begin
				// Look at the following entry while more than one frame is left
				if (flags.count_gt1) begin
					cmd.rd_next = 1'b1;
					state_d     = S_NEXT_CHK;
				end else begin
					cmd.pop      = 1'b1;
					cmd.use_hold = 1'b1;
					cmd.finish   = 1'b1;
					cmd.status   = ST_DONE;
					state_d      = S_IDLE;
				end
			end
			S_NEXT_CHK: begin
				if (flags.rd_later) begin
					cmd.pop      = 1'b1;
					cmd.use_hold = 1'b1;
					cmd.finish   = 1'b1;
					cmd.status   = ST_DONE;
					state_d      = S_IDLE;
				end else begin
					// Drop the head, the following entry becomes the candidate
					cmd.advance   = 1'b1;
					cmd.load_hold = 1'b1;
					state_d       = S_NEXT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= cmd.finish;
			if (cmd.accept) begin
				busy <= 1'b1;
			end else if (cmd.finish) begin
				busy <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/playout_jitter_buffer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                       Payload
// request   in         start, taken when busy is low    req_type, frame_descriptor,
//                                                      frame_stamp, target_stamp
// result    out        done, one-cycle strobe          status, out_descriptor, out_stamp,
//                                                      is_buffering, fill_level
// config    in         APB write, psel&penable&pwrite  paddr, pwdata, prdata
//
// A put, a reset request or a refused take ends in S_EXEC, a plain take pops
// the head in S_TAKE_CHK. A timed take checks the head in S_HEAD_CHK, reads
// and checks each entry past it in S_NEXT_RD and S_NEXT_CHK, and ends in
// S_NEXT_RD when the walk reaches the last frame: the walk shares the single
// registered read port of the entry store. busy stays high until the cycle
// that carries done, so one item is worked at a time. The receiver cannot
// stall; each result is shown for one cycle only. Reset empties the queue and
// sets buffering at once; the entry store itself is not cleared.

module playout_jitter_buffer
	import pjb_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [DESC_W-1:0]         frame_descriptor,
	input  logic signed [STAMP_W-1:0] frame_stamp,
	input  logic signed [STAMP_W-1:0] target_stamp,
	output logic                      done,
	output logic [1:0]                status,
	output logic [DESC_W-1:0]         out_descriptor,
	output logic signed [STAMP_W-1:0] out_stamp,
	output logic                      is_buffering,
	output logic [FILL_W-1:0]         fill_level,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	cmd_t             cmd;
	flags_t           flags;
	logic [THR_W-1:0] threshold_q;
	logic             thr_sel;

	// Threshold register at word 0
	assign thr_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = thr_sel ? {{(32 - THR_W){1'b0}}, threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && thr_sel) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	pjb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.flags  (flags),
		.cmd    (cmd)
	);

	pjb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.flags            (flags),
		.req_type         (req_type),
		.frame_descriptor (frame_descriptor),
		.frame_stamp      (frame_stamp),
		.target_stamp     (target_stamp),
		.threshold        (threshold_q),
		.status           (status),
		.out_descriptor   (out_descriptor),
		.out_stamp        (out_stamp),
		.is_buffering     (is_buffering),
		.fill_level       (fill_level)
	);

endmodule

// File: bench/playout_jitter_buffer_tb.sv
`timescale 1ns / 1ps

module playout_jitter_buffer_tb;
	import pjb_pkg::*;

	localparam int DEPTH         = 16;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int STALL_LIMIT   = 1000;
	localparam logic [2:0] THR_ADDR = 3'd0;
	localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
	localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};

	typedef struct {
		req_t                      req;
		logic [DESC_W-1:0]         desc;
		logic signed [STAMP_W-1:0] pts;
		logic signed [STAMP_W-1:0] tgt;
	} request_t;

	typedef struct {
		logic [DESC_W-1:0]         desc;
		logic signed [STAMP_W-1:0] stamp;
	} frame_t;

	typedef struct {
		status_t                   status;
		logic [DESC_W-1:0]         desc;
		logic signed [STAMP_W-1:0] stamp;
		logic                      buffering;
		logic [FILL_W-1:0]         fill;
	} playout_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [1:0]                req_type = REQ_PUT;
	logic [DESC_W-1:0]         frame_descriptor = '0;
	logic signed [STAMP_W-1:0] frame_stamp = '0;
	logic signed [STAMP_W-1:0] target_stamp = '0;
	logic                      done;
	logic [1:0]                status;
	logic [DESC_W-1:0]         out_descriptor;
	logic signed [STAMP_W-1:0] out_stamp;
	logic                      is_buffering;
	logic [FILL_W-1:0]         fill_level;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [2:0]                paddr = THR_ADDR;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;

	// Shadow of the block: frames held, buffering flag and threshold
	frame_t            held_frames[$];
	logic              buffering_model = 1'b1;
	logic [THR_W-1:0]  threshold_model = THR_RESET;

	request_t          pending_requests[$];
	playout_t          expected_playout[$];
	int                idle_pct = 32;
	int                error_count = 0;
	logic signed [STAMP_W-1:0] stamp_cursor = '0;
	logic signed [STAMP_W-1:0] recent_stamps[$];

	playout_jitter_buffer #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .frame_descriptor(frame_descriptor),
		.frame_stamp(frame_stamp), .target_stamp(target_stamp),
		.done(done), .status(status), .out_descriptor(out_descriptor),
		.out_stamp(out_stamp), .is_buffering(is_buffering), .fill_level(fill_level),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// Pop the head frame; an emptied queue goes back to buffering
	function automatic frame_t release_head();
		frame_t f;
		f = held_frames.pop_front();
		if (held_frames.size() == 0)
			buffering_model = 1'b1;
		return f;
	endfunction

	// Work out the playout result of one request and advance the shadow state
	function automatic playout_t predict_playout(req_t req, logic [DESC_W-1:0] desc,
			logic signed [STAMP_W-1:0] pts, logic signed [STAMP_W-1:0] tgt);
		playout_t r;
		frame_t   f;
		r.status = ST_DONE;
		r.desc   = '0;
		r.stamp  = '0;
		case (req)
			REQ_PUT: begin
				if (held_frames.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					f.desc  = desc;
					f.stamp = pts;
					held_frames.push_back(f);
					if (buffering_model && held_frames.size() >= threshold_model)
						buffering_model = 1'b0;
				end
			end
			REQ_TAKE: begin
				if (buffering_model || held_frames.size() == 0) begin
					r.status = ST_BUFFERING;
				end else begin
					f = release_head();
					r.desc  = f.desc;
					r.stamp = f.stamp;
				end
			end
			REQ_TIMED: begin
				if (buffering_model || held_frames.size() == 0) begin
					r.status = ST_BUFFERING;
				end else if (held_frames[0].stamp > tgt) begin
					r.status = ST_LATE;
				end else begin
					// drop stale heads while the next frame is still due
					if (held_frames[0].stamp != tgt)
						while (held_frames.size() > 1 && !(held_frames[1].stamp > tgt))
							void'(held_frames.pop_front());
					f = release_head();
					r.desc  = f.desc;
					r.stamp = f.stamp;
				end
			end
			default: begin
				held_frames.delete();
				buffering_model = 1'b1;
			end
		endcase
		r.buffering = buffering_model;
		r.fill      = FILL_W'(held_frames.size());
		return r;
	endfunction

	// Driver: predict the item taken at this edge, then offer the next one
	always @(posedge clk) begin
		request_t nxt;
		if (arst_n) begin
			if (start && !busy)
				expected_playout.push_back(predict_playout(req_t'(req_type),
					frame_descriptor, frame_stamp, target_stamp));
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_requests.pop_front();
					start            <= 1'b1;
					req_type         <= nxt.req;
					frame_descriptor <= nxt.desc;
					frame_stamp      <= nxt.pts;
					target_stamp     <= nxt.tgt;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each strobed result against the oldest expectation
	always @(posedge clk) begin
		playout_t want;
		if (arst_n && done) begin
			if (expected_playout.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(status), '0);
			end else begin
				want = expected_playout.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (out_descriptor !== want.desc)
					report_mismatch("out_descriptor", 64'(out_descriptor),
						64'(want.desc));
				if (out_stamp !== want.stamp)
					report_mismatch("out_stamp", out_stamp, want.stamp);
				if (is_buffering !== want.buffering)
					report_mismatch("is_buffering", 64'(is_buffering),
						64'(want.buffering));
				if (fill_level !== want.fill)
					report_mismatch("fill_level", 64'(fill_level), 64'(want.fill));
			end
		end
	end

	// Watchdog: end the run after too long with no item moving
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("playout_jitter_buffer_tb failed");
		$finish;
	end

	task automatic add_request(req_t req, logic [DESC_W-1:0] desc,
			logic signed [STAMP_W-1:0] pts, logic signed [STAMP_W-1:0] tgt);
		request_t q;
		q.req  = req;
		q.desc = desc;
		q.pts  = pts;
		q.tgt  = tgt;
		pending_requests.push_back(q);
	endtask

	// Hold the sender until every result is in, then let the block settle
	task automatic drain_and_settle();
		while (pending_requests.size() != 0 || start || expected_playout.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Set the threshold while idle, then queue a run of mostly ordered traffic
	task automatic run_phase(logic [THR_W-1:0] thr, int idle, int put_pct, int n);
		logic [31:0]               wr;
		logic signed [STAMP_W-1:0] pts;
		logic signed [STAMP_W-1:0] tgt;
		req_t                      req;
		int                        roll;
		drain_and_settle();
		wr = $urandom();
		wr[THR_W-1:0] = thr;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= THR_ADDR;
		pwdata  <= wr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		threshold_model = thr;
		idle_pct = idle;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < put_pct) begin
				req = REQ_PUT;
			end else begin
				roll = $urandom_range(99);
				req = (roll < 35) ? REQ_TAKE : (roll < 93) ? REQ_TIMED : REQ_RESET;
			end
			// advance the stamp mostly in order, with jumps and reorders
			pts  = {$urandom(), $urandom()};
			roll = $urandom_range(99);
			if (req == REQ_PUT) begin
				if (roll < 80)
					stamp_cursor = stamp_cursor + STAMP_W'($urandom_range(1, 4));
				else if (roll < 85)
					stamp_cursor = pts;
				else if (roll < 88)
					stamp_cursor = STAMP_MAX - STAMP_W'($urandom_range(0, 20));
				else if (roll < 94)
					stamp_cursor = stamp_cursor - STAMP_W'($urandom_range(0, 3));
				if (roll < 94)
					pts = stamp_cursor;
				recent_stamps.push_back(pts);
				if (recent_stamps.size() > DEPTH)
					void'(recent_stamps.pop_front());
			end
			// aim the target near stamps that are likely still held
			tgt  = {$urandom(), $urandom()};
			roll = $urandom_range(99);
			if (recent_stamps.size() == 0)
				tgt = stamp_cursor;
			else if (roll < 55)
				tgt = recent_stamps[$urandom_range(recent_stamps.size() - 1)]
					+ STAMP_W'($urandom_range(0, 2)) - STAMP_W'(1);
			else if (roll < 75)
				tgt = recent_stamps[recent_stamps.size() - 1]
					+ STAMP_W'($urandom_range(0, 30));
			else if (roll < 85)
				tgt = recent_stamps[0] - STAMP_W'($urandom_range(0, 5));
			else if (roll < 95)
				tgt = (roll < 90) ? STAMP_MIN : STAMP_MAX;
			add_request(req, $urandom(), pts, tgt);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty queue, stamp extremes, refusals, walks, reset request
		add_request(REQ_TAKE,  32'h1234_5678, 64'sd0, 64'sd0);
		add_request(REQ_TIMED, 32'h0, 64'sd0, 64'sd0);
		add_request(REQ_RESET, 32'hFFFF_FFFF, STAMP_MAX, STAMP_MIN);
		add_request(REQ_PUT,   32'h0000_0000, STAMP_MIN, STAMP_MAX);
		add_request(REQ_PUT,   32'hFFFF_FFFF, -64'sd1, 64'sd0);
		add_request(REQ_TAKE,  32'h0, 64'sd0, 64'sd0);
		add_request(REQ_PUT,   32'hA5A5_5A5A, 64'sd0, -64'sd1);
		add_request(REQ_PUT,   32'h5A5A_A5A5, STAMP_MAX, 64'sd0);
		add_request(REQ_TIMED, 32'h0, 64'sd0, STAMP_MIN);
		add_request(REQ_TIMED, 32'h0, 64'sd0, -64'sd2);
		add_request(REQ_TAKE,  32'h0, 64'sd0, 64'sd0);
		add_request(REQ_TIMED, 32'h0, 64'sd0, 64'sd5);
		add_request(REQ_TIMED, 32'h0, 64'sd0, STAMP_MAX);
		add_request(REQ_PUT,   32'h0000_0100, 64'sd100, 64'sd0);
		add_request(REQ_PUT,   32'h0000_0101, 64'sd101, 64'sd0);
		add_request(REQ_PUT,   32'h0000_0102, 64'sd102, 64'sd0);
		add_request(REQ_TIMED, 32'h0, 64'sd0, STAMP_MAX);
		add_request(REQ_PUT,   32'h0000_0007, 64'sd7, 64'sd0);
		add_request(REQ_RESET, 32'h0, 64'sd0, 64'sd0);
		add_request(REQ_TAKE,  32'h0, 64'sd0, 64'sd0);

		// Random phases across thresholds, idling on and off
		run_phase(5'd0,  32, 45, 300);
		run_phase(5'd16,  0, 75, 300);
		run_phase(5'd1,  32, 50, 300);
		run_phase(5'd31, 32, 60, 100);
		run_phase(5'd5,  32, 55, 400);
		run_phase(5'd3,  32, 50, 300);
		drain_and_settle();

		if (error_count == 0)
			$display("playout_jitter_buffer_tb passed");
		else
			$display("playout_jitter_buffer_tb failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pjb_pkg.sv
hw/rtl/pjb_datapath.sv
hw/rtl/pjb_ctrl.sv
hw/rtl/playout_jitter_buffer.sv
bench/playout_jitter_buffer_tb.sv
